// ===== rtl/core/sms_pkg.sv =====
package sms_pkg;

    // Field widths
    localparam int DATA_W = 31;
    localparam int MOD_W  = 30;

    // Default stack depth
    localparam int MAX_LEN_DEF = 1024;

    // Modulus and its double, at value width
    localparam logic [DATA_W-1:0] MODULUS    = 31'd1000000007;
    localparam logic [DATA_W-1:0] MODULUS_X2 = 31'd2000000014;

    // Reciprocal for the reduction: floor(2^(RECIP_SHIFT+MOD_W) / MODULUS)
    localparam int RECIP_SHIFT = 29;
    localparam logic [63:0] RECIP_WIDE =
        (64'd1 << (RECIP_SHIFT + MOD_W)) / 64'(MODULUS);
    localparam logic [MOD_W-1:0] RECIP = RECIP_WIDE[MOD_W-1:0];

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              last;
    } item_t;

    typedef struct packed {
        logic [MOD_W-1:0] total;
        logic             overflow;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CMP,
        ST_MUL,
        ST_QEST,
        ST_QMUL,
        ST_RSUB,
        ST_FIX,
        ST_PUSH,
        ST_ADD,
        ST_EMIT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_OVF,
        OP_POP,
        OP_MUL,
        OP_QEST,
        OP_QMUL,
        OP_RSUB,
        OP_FIX,
        OP_PUSH,
        OP_ADD,
        OP_EMIT
    } op_t;

    typedef struct packed {
        logic len_full;
        logic top_zero;
        logic top_one;
        logic ge;
        logic last;
        logic out_busy;
    } status_t;

endpackage

// ===== rtl/core/subarray_min_sum.sv =====
// An item is loaded, pops each stack entry not smaller than it (a compare step ends
//   the pops unless they empty the stack), then passes multiply, reduction, push
//   and add; a dropped item only sets overflow. The final item then waits in the emit
//   step while an earlier result is stalled; its result shows on the cycle after it.
// Throughput is one item at a time, bound by the pop loop and the modular multiply.
// Reset (rst_n low, asynchronous) empties the stack and clears all sums; no RAM clear.
module subarray_min_sum #(
    parameter int MAX_LEN = sms_pkg::MAX_LEN_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  sms_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output sms_pkg::result_t result
);

    sms_pkg::op_t     op;
    sms_pkg::status_t status;

    sms_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_last  (item.last),
        .status     (status),
        .op         (op),
        .item_stall (item_stall)
    );

    sms_dp #(
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (op),
        .item         (item),
        .result_stall (result_stall),
        .status       (status),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

// ===== rtl/core/sms_ram.sv =====
module sms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port, registered read port (read-first)
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/sms_ctrl.sv =====
module sms_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  logic             item_last,
    input  sms_pkg::status_t status,
    output sms_pkg::op_t     op,
    output logic             item_stall
);

    sms_pkg::state_t state_reg;
    sms_pkg::state_t state_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sms_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sms_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    if (status.len_full)
                    begin
                        state_next = item_last ? sms_pkg::ST_EMIT : sms_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = status.top_zero ? sms_pkg::ST_MUL : sms_pkg::ST_CMP;
                    end
                end
            end
            sms_pkg::ST_CMP:
            begin
                if (!status.ge || status.top_one)
                begin
                    state_next = sms_pkg::ST_MUL;
                end
            end
            sms_pkg::ST_MUL:  state_next = sms_pkg::ST_QEST;
            sms_pkg::ST_QEST: state_next = sms_pkg::ST_QMUL;
            sms_pkg::ST_QMUL: state_next = sms_pkg::ST_RSUB;
            sms_pkg::ST_RSUB: state_next = sms_pkg::ST_FIX;
            sms_pkg::ST_FIX:  state_next = sms_pkg::ST_PUSH;
            sms_pkg::ST_PUSH: state_next = sms_pkg::ST_ADD;
            sms_pkg::ST_ADD:
            begin
                state_next = status.last ? sms_pkg::ST_EMIT : sms_pkg::ST_IDLE;
            end
            sms_pkg::ST_EMIT:
            begin
                if (!status.out_busy)
                begin
                    state_next = sms_pkg::ST_IDLE;
                end
            end
            default: state_next = sms_pkg::ST_IDLE;
        endcase
    end

    // Commands to the datapath
    always_comb
    begin
        op         = sms_pkg::OP_NONE;
        item_stall = 1'b1;
        case (state_reg)
            sms_pkg::ST_IDLE:
            begin
                item_stall = 1'b0;
                if (item_valid)
                begin
                    op = status.len_full ? sms_pkg::OP_OVF : sms_pkg::OP_LOAD;
                end
            end
            sms_pkg::ST_CMP:
            begin
                if (status.ge)
                begin
                    op = sms_pkg::OP_POP;
                end
            end
            sms_pkg::ST_MUL:  op = sms_pkg::OP_MUL;
            sms_pkg::ST_QEST: op = sms_pkg::OP_QEST;
            sms_pkg::ST_QMUL: op = sms_pkg::OP_QMUL;
            sms_pkg::ST_RSUB: op = sms_pkg::OP_RSUB;
            sms_pkg::ST_FIX:  op = sms_pkg::OP_FIX;
            sms_pkg::ST_PUSH: op = sms_pkg::OP_PUSH;
            sms_pkg::ST_ADD:  op = sms_pkg::OP_ADD;
            sms_pkg::ST_EMIT:
            begin
                if (!status.out_busy)
                begin
                    op = sms_pkg::OP_EMIT;
                end
            end
            default: op = sms_pkg::OP_NONE;
        endcase
    end

endmodule

// ===== rtl/core/sms_dp.sv =====
module sms_dp #(
    parameter int MAX_LEN = sms_pkg::MAX_LEN_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  sms_pkg::op_t      op,
    input  sms_pkg::item_t    item,
    input  logic              result_stall,
    output sms_pkg::status_t  status,
    output logic              result_valid,
    output sms_pkg::result_t  result
);

    localparam int DW = sms_pkg::DATA_W;
    localparam int MW = sms_pkg::MOD_W;
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int EW = DW + CW + MW;
    localparam int PW = MW + CW;
    localparam int QW = PW - sms_pkg::RECIP_SHIFT;
    localparam int TW = QW + MW;
    localparam int RW = MW + 2;

    function automatic logic [MW-1:0] add_mod(input logic [MW-1:0] a, input logic [MW-1:0] b);
        logic [DW-1:0] s;
        begin
            s = DW'(a) + DW'(b);
            add_mod = (s >= sms_pkg::MODULUS) ? MW'(s - sms_pkg::MODULUS) : MW'(s);
        end
    endfunction

    function automatic logic [MW-1:0] sub_mod(input logic [MW-1:0] a, input logic [MW-1:0] b);
        logic [DW-1:0] s;
        begin
            s = (a >= b) ? DW'(a) - DW'(b) : DW'(a) + sms_pkg::MODULUS - DW'(b);
            sub_mod = MW'(s);
        end
    endfunction

    // Control state
    logic [CW-1:0]    top_reg, top_next;
    logic [CW-1:0]    length_reg, length_next;
    logic [MW-1:0]    ending_reg, ending_next;
    logic [MW-1:0]    grand_reg, grand_next;
    logic             ovf_reg, ovf_next;
    logic             result_valid_reg, result_valid_next;

    // Payload state
    logic [DW-1:0]    x_reg, x_next;
    logic [MW-1:0]    xm_reg, xm_next;
    logic             last_reg, last_next;
    logic [CW-1:0]    run_reg, run_next;
    logic [PW-1:0]    prod_reg, prod_next;
    logic [QW-1:0]    qest_reg, qest_next;
    logic [PW-1:0]    qm_reg, qm_next;
    logic [RW-1:0]    rem_reg, rem_next;
    logic [MW-1:0]    contrib_reg, contrib_next;
    sms_pkg::result_t result_reg, result_next;

    // Stack memory signals
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [EW-1:0]    wr_data;
    logic [AW-1:0]    rd_addr;
    logic [EW-1:0]    rd_data;
    logic [CW-1:0]    top_dec;
    logic [DW-1:0]    rd_value;
    logic [CW-1:0]    rd_count;
    logic [MW-1:0]    rd_contrib;

    // Arithmetic intermediates
    logic [DW-1:0]    xm_wide;
    logic [TW-1:0]    recip_prod;
    logic [PW:0]      qm_full;
    logic [PW-1:0]    diff;

    sms_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_LEN)
    ) u_stack (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Split the top entry
    assign rd_value   = rd_data[EW-1 -: DW];
    assign rd_count   = rd_data[MW +: CW];
    assign rd_contrib = rd_data[MW-1:0];

    // Keep the read port on the entry below the next top
    assign top_dec = top_next - CW'(1);
    assign rd_addr = top_dec[AW-1:0];

    // Stack write on push
    assign wr_en   = (op == sms_pkg::OP_PUSH);
    assign wr_addr = top_reg[AW-1:0];
    assign wr_data = {x_reg, run_reg, contrib_reg};

    // Reduce the incoming value below the modulus
    always_comb
    begin
        if (item.value >= sms_pkg::MODULUS_X2)
        begin
            xm_wide = item.value - sms_pkg::MODULUS_X2;
        end
        else if (item.value >= sms_pkg::MODULUS)
        begin
            xm_wide = item.value - sms_pkg::MODULUS;
        end
        else
        begin
            xm_wide = item.value;
        end
    end

    assign recip_prod = TW'(prod_reg[PW-1:sms_pkg::RECIP_SHIFT]) * TW'(sms_pkg::RECIP);
    assign qm_full    = (PW + 1)'(qest_reg) * (PW + 1)'(sms_pkg::MODULUS);
    assign diff       = prod_reg - qm_reg;

    // Next values per command
    always_comb
    begin
        top_next          = top_reg;
        length_next       = length_reg;
        ending_next       = ending_reg;
        grand_next        = grand_reg;
        ovf_next          = ovf_reg;
        result_valid_next = result_valid_reg && result_stall;
        x_next            = x_reg;
        xm_next           = xm_reg;
        last_next         = last_reg;
        run_next          = run_reg;
        prod_next         = prod_reg;
        qest_next         = qest_reg;
        qm_next           = qm_reg;
        rem_next          = rem_reg;
        contrib_next      = contrib_reg;
        result_next       = result_reg;
        case (op)
            sms_pkg::OP_LOAD:
            begin
                x_next    = item.value;
                xm_next   = xm_wide[MW-1:0];
                last_next = item.last;
                run_next  = CW'(1);
            end
            sms_pkg::OP_OVF:
            begin
                ovf_next = 1'b1;
            end
            sms_pkg::OP_POP:
            begin
                top_next    = top_reg - CW'(1);
                run_next    = run_reg + rd_count;
                ending_next = sub_mod(ending_reg, rd_contrib);
            end
            sms_pkg::OP_MUL:
            begin
                prod_next = PW'(xm_reg) * PW'(run_reg);
            end
            sms_pkg::OP_QEST:
            begin
                qest_next = recip_prod[TW-1:MW];
            end
            sms_pkg::OP_QMUL:
            begin
                qm_next = qm_full[PW-1:0];
            end
            sms_pkg::OP_RSUB:
            begin
                rem_next = RW'(diff);
            end
            sms_pkg::OP_FIX:
            begin
                if (rem_reg >= RW'(sms_pkg::MODULUS_X2))
                begin
                    contrib_next = MW'(rem_reg - RW'(sms_pkg::MODULUS_X2));
                end
                else if (rem_reg >= RW'(sms_pkg::MODULUS))
                begin
                    contrib_next = MW'(rem_reg - RW'(sms_pkg::MODULUS));
                end
                else
                begin
                    contrib_next = MW'(rem_reg);
                end
            end
            sms_pkg::OP_PUSH:
            begin
                top_next    = top_reg + CW'(1);
                ending_next = add_mod(ending_reg, contrib_reg);
            end
            sms_pkg::OP_ADD:
            begin
                grand_next  = add_mod(grand_reg, ending_reg);
                length_next = length_reg + CW'(1);
            end
            sms_pkg::OP_EMIT:
            begin
                result_next.total    = grand_reg;
                result_next.overflow = ovf_reg;
                result_valid_next    = 1'b1;
                top_next             = '0;
                length_next          = '0;
                ending_next          = '0;
                grand_next           = '0;
                ovf_next             = 1'b0;
            end
            default:
            begin
                top_next = top_reg;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg          <= '0;
            length_reg       <= '0;
            ending_reg       <= '0;
            grand_reg        <= '0;
            ovf_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            top_reg          <= top_next;
            length_reg       <= length_next;
            ending_reg       <= ending_next;
            grand_reg        <= grand_next;
            ovf_reg          <= ovf_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        x_reg       <= x_next;
        xm_reg      <= xm_next;
        last_reg    <= last_next;
        run_reg     <= run_next;
        prod_reg    <= prod_next;
        qest_reg    <= qest_next;
        qm_reg      <= qm_next;
        rem_reg     <= rem_next;
        contrib_reg <= contrib_next;
        result_reg  <= result_next;
    end

    // Status to the controller
    assign status.len_full = (length_reg == CW'(MAX_LEN));
    assign status.top_zero = (top_reg == '0);
    assign status.top_one  = (top_reg == CW'(1));
    assign status.ge       = (rd_value >= x_reg);
    assign status.last     = last_reg;
    assign status.out_busy = result_valid_reg && result_stall;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTHESIS
    a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
        (op == sms_pkg::OP_POP) |=> (top_reg + CW'(1) == $past(top_reg)))
        else $error("stack top did not drop on pop");

    // the pushed entry is counted on the add step that follows the push
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (op != sms_pkg::OP_ADD) |-> (top_reg <= length_reg))
        else $error("stack deeper than items seen");

    a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (op == sms_pkg::OP_FIX) |=> (DW'(contrib_reg) < sms_pkg::MODULUS))
        else $error("contribution not reduced below modulus");

    a_emit_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (op == sms_pkg::OP_EMIT) |=> (top_reg == '0 && length_reg == '0 && result_valid_reg))
        else $error("sequence state not cleared on result");

    a_sums: assert property (@(posedge clk) disable iff (!rst_n)
        (DW'(ending_reg) < sms_pkg::MODULUS) && (DW'(grand_reg) < sms_pkg::MODULUS))
        else $error("running sums out of range");
`endif

endmodule

// ===== bench/tb_subarray_min_sum.sv =====
`timescale 1ns / 1ps

module tb_subarray_min_sum;

    localparam int CAP          = sms_pkg::MAX_LEN_DEF;
    localparam int DW           = sms_pkg::DATA_W;
    localparam int MW           = sms_pkg::MOD_W;
    localparam int LONG_HOLD    = 300;
    localparam int TAIL_CYCLES  = 40;
    localparam int RANDOM_ITEMS = 220;
    localparam longint unsigned MOD = longint'(sms_pkg::MODULUS);
    localparam logic [DW-1:0] ALL_ONES = '1;

    typedef enum int {
        VAL_TINY,
        VAL_ANY,
        VAL_TOP,
        VAL_NEAR_MOD,
        VAL_MIXED
    } value_style_t;

    logic             clk;
    logic             rst_n;
    logic             item_valid;
    logic             item_stall;
    sms_pkg::item_t   item;
    logic             result_valid;
    logic             result_stall;
    sms_pkg::result_t result;

    // Mirror of the block's state
    logic [DW-1:0]     mono_value [CAP];
    longint unsigned   mono_run   [CAP];
    longint unsigned   mono_part  [CAP];
    int                mono_depth;
    longint unsigned   tail_sum;
    longint unsigned   running_total;
    int                seq_len;
    logic              seq_dropped;

    sms_pkg::result_t pending_totals [$];

    int  errors;
    int  n_items;
    int  n_sequences;
    int  n_checked;
    int  n_overflow;
    int  longest_seq;
    int  input_stall_cycles;
    bit  no_gaps;
    int  hold_req;
    int  hold_seen;
    int  stall_left;

    subarray_min_sum #(
        .MAX_LEN(CAP)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Abort a hung run
    initial
    begin
        #1000000;
        $display("Regression FAIL");
        $finish;
    end

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (no_gaps)
            return 0;
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [DW-1:0] pick_value(value_style_t style);
        value_style_t s;
        logic [31:0]  raw;
        s = style;
        if (s == VAL_MIXED)
            s = value_style_t'($urandom_range(0, 3));
        raw = $urandom;
        case (s)
            VAL_TINY:     return DW'($urandom_range(0, 7));
            VAL_TOP:      return ALL_ONES - DW'($urandom_range(0, 3));
            VAL_NEAR_MOD: return sms_pkg::MODULUS - DW'(2) + DW'($urandom_range(0, 4));
            default:      return raw[DW-1:0];
        endcase
    endfunction

    function automatic void clear_sequence();
        mono_depth    = 0;
        tail_sum      = 0;
        running_total = 0;
        seq_len       = 0;
        seq_dropped   = 1'b0;
    endfunction

    // Advance the mirror by one value; return 1 when a total is due
    function automatic bit min_sum_step(input logic [DW-1:0] v, input logic fin,
                                        output sms_pkg::result_t r);
        longint unsigned run;
        longint unsigned part;
        longint unsigned xv;
        r = '0;
        if (seq_len >= CAP)
        begin
            seq_dropped = 1'b1;
        end
        else
        begin
            xv  = longint'(v);
            run = 1;
            // pop every entry not smaller than the new value
            while (mono_depth > 0 && mono_value[mono_depth-1] >= v)
            begin
                mono_depth--;
                run += mono_run[mono_depth];
                tail_sum = (tail_sum + MOD - mono_part[mono_depth]) % MOD;
            end
            part = ((xv % MOD) * run) % MOD;
            mono_value[mono_depth] = v;
            mono_run[mono_depth]   = run;
            mono_part[mono_depth]  = part;
            mono_depth++;
            tail_sum      = (tail_sum + part) % MOD;
            running_total = (running_total + tail_sum) % MOD;
            seq_len++;
        end
        if (!fin)
            return 0;
        r.total    = running_total[MW-1:0];
        r.overflow = seq_dropped;
        clear_sequence();
        return 1;
    endfunction

    // Offer one value until the transfer happens, then maybe idle
    task automatic send_item(input logic [DW-1:0] v, input logic fin);
        sms_pkg::result_t r;
        int               gap;
        item_valid <= 1'b1;
        item       <= '{value: v, last: fin};
        do
        begin
            @(posedge clk);
            if (item_stall)
                input_stall_cycles++;
        end
        while (item_stall);
        n_items++;
        if (min_sum_step(v, fin, r))
        begin
            pending_totals.push_back(r);
            if (r.overflow)
                n_overflow++;
        end
        gap = pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_run(input logic [DW-1:0] vals[$]);
        foreach (vals[i])
            send_item(vals[i], i == vals.size() - 1);
        n_sequences++;
        if (vals.size() > longest_seq)
            longest_seq = vals.size();
    endtask

    task automatic send_random_sequence(input int len, input value_style_t style);
        logic [DW-1:0] vals[$];
        repeat (len) vals.push_back(pick_value(style));
        send_run(vals);
    endtask

    // Hold the input low until every expected total has come back
    task automatic wait_drained();
        item_valid <= 1'b0;
        do @(posedge clk); while (pending_totals.size() != 0);
    endtask

    task automatic test_directed();
        logic [DW-1:0] vals[$];
        vals = {31'd0};
        send_run(vals);
        vals = {ALL_ONES};
        send_run(vals);
        vals = {sms_pkg::MODULUS};
        send_run(vals);
        vals = {31'd3, 31'd1, 31'd2, 31'd4};
        send_run(vals);
        // equal values pop each other
        vals = {31'd5, 31'd5, 31'd5};
        send_run(vals);
        vals = {31'd9, 31'd7, 31'd4, 31'd1};
        send_run(vals);
        vals = {31'd1, 31'd2, 31'd3};
        send_run(vals);
        // values above the modulus exercise the input reduction
        vals = {ALL_ONES, ALL_ONES, 31'd0, ALL_ONES};
        send_run(vals);
        wait_drained();
    endtask

    task automatic test_full_length();
        logic [DW-1:0] vals[$];
        // rising values fill the stack to the top, then two are dropped
        for (int i = 1; i <= CAP + 2; i++)
            vals.push_back(DW'(i * 2097151));
        send_run(vals);
        wait_drained();
    endtask

    task automatic test_backpressure();
        // receiver holds off while the sender keeps offering
        hold_req++;
        for (int i = 0; i < 6; i++)
            send_random_sequence(3, VAL_MIXED);
        wait_drained();
    endtask

    task automatic test_random();
        int sent;
        int len;
        int r;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            r = $urandom_range(99);
            if (r < 70)
                len = $urandom_range(1, 12);
            else if (r < 95)
                len = $urandom_range(13, 60);
            else
                len = $urandom_range(61, 200);
            // a stretch with no idling on either side
            no_gaps = (n_sequences % 8) >= 5;
            send_random_sequence(len, value_style_t'($urandom_range(0, 4)));
            sent += len;
            if ($urandom_range(0, 19) == 0)
                wait_drained();
        end
        no_gaps = 1'b0;
        wait_drained();
    endtask

    // Receiver side: random stall, plus a long hold on request
    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen  = hold_req;
            stall_left = LONG_HOLD;
        end
        else if (stall_left == 0)
        begin
            stall_left = pick_gap();
        end
        if (stall_left > 0)
        begin
            result_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            result_stall <= 1'b0;
        end
    end

    // Compare each result transfer with the oldest expected total
    always @(posedge clk)
    begin
        sms_pkg::result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_totals.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result: expected none, actual %0d/%0b",
                         $time, result.total, result.overflow);
            end
            else
            begin
                want = pending_totals.pop_front();
                n_checked++;
                if (want.total !== result.total)
                begin
                    errors++;
                    $display("%0t: total mismatch: expected %0d, actual %0d",
                             $time, want.total, result.total);
                end
                if (want.overflow !== result.overflow)
                begin
                    errors++;
                    $display("%0t: overflow mismatch: expected %0b, actual %0b",
                             $time, want.overflow, result.overflow);
                end
            end
        end
    end

    initial
    begin
        rst_n              = 1'b0;
        item_valid         = 1'b0;
        item               = '0;
        result_stall       = 1'b0;
        errors             = 0;
        n_items            = 0;
        n_sequences        = 0;
        n_checked          = 0;
        n_overflow         = 0;
        longest_seq        = 0;
        input_stall_cycles = 0;
        no_gaps            = 1'b0;
        hold_req           = 0;
        hold_seen          = 0;
        stall_left         = 0;
        clear_sequence();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full_length();
        test_backpressure();
        test_random();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_totals.size() != 0)
            errors++;

        $display("Sent %0d sequences (%0d values, longest %0d), checked %0d totals",
                 n_sequences, n_items, longest_seq, n_checked);
        $display("Totals with dropped values: %0d; input held off for %0d cycles",
                 n_overflow, input_stall_cycles);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
